// File: rtl/core/sm3_hash_core_defines.svh
`ifndef SM3_HASH_CORE_DEFINES_SVH
`define SM3_HASH_CORE_DEFINES_SVH

// Property checked on every edge, reset included.
`define SM3_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// Property checked only outside reset.
`define SM3_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// File: rtl/core/sm3_pkg.sv
package sm3_pkg;

    localparam logic [31:0] SM3_T_LOW  = 32'h79cc4519;
    localparam logic [31:0] SM3_T_HIGH = 32'h7a879d8a;
    // round 16 uses the high constant rotated left by 16
    localparam logic [31:0] SM3_T_HIGH_R16 = {SM3_T_HIGH[15:0], SM3_T_HIGH[31:16]};

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    localparam int SM3_ROUNDS = 64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       shift_in;   // take a message word into the schedule window
        logic       load_iv;    // reload the chaining value with the initial value
        logic       start;      // load working variables, arm the round constant
        logic       round;      // run one compression round
        logic       round_hi;   // rounds 16..63 use majority and choose
        logic       t_switch;   // swap in the high round constant after round 15
        logic       finish;     // fold working variables into the chaining value
        logic [2:0] out_idx;    // digest word on the output
    } t_cmd;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage

// File: rtl/core/sm3_ctrl.sv
`include "sm3_hash_core_defines.svh"

module sm3_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_first_word,
    input  logic          i_final_word,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_digest_last,
    output sm3_pkg::t_cmd o_cmd
);
    import sm3_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ROUND  = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    localparam logic [5:0] LAST_ROUND = 6'(SM3_ROUNDS - 1);

    logic [1:0] r_state, n_state;
    logic [3:0] r_pos, n_pos;
    logic [5:0] r_round, n_round;
    logic [2:0] r_out_idx, n_out_idx;
    logic       r_final, n_final;

    logic       accept;
    logic [3:0] pos_eff;
    logic       wrap;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_digest_last = (r_out_idx == 3'd7);

    assign accept  = i_in_valid && o_in_ready;
    assign pos_eff = i_first_word ? 4'd0 : r_pos;
    assign wrap    = accept && (pos_eff == 4'd15);

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_round   = r_round;
        n_out_idx = r_out_idx;
        n_final   = r_final;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pos = pos_eff + 4'd1;
                end
                if (wrap) begin
                    n_state = S_ROUND;
                    n_round = 6'd0;
                    n_final = i_final_word;
                end
            end
            S_ROUND: begin
                n_round = r_round + 6'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_out_idx = 3'd0;
                n_state   = r_final ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= 4'd0;
            r_round   <= 6'd0;
            r_out_idx <= 3'd0;
            r_final   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_round   <= n_round;
            r_out_idx <= n_out_idx;
            r_final   <= n_final;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.shift_in = accept;
        o_cmd.load_iv  = accept && i_first_word;
        o_cmd.start    = wrap;
        o_cmd.round    = (r_state == S_ROUND);
        o_cmd.round_hi = (r_round[5:4] != 2'd0);
        o_cmd.t_switch = (r_round == 6'd15);
        o_cmd.finish   = (r_state == S_FINISH);
        o_cmd.out_idx  = r_out_idx;
    end

    `SM3_ASSERT(a_ready_excludes_out, !(o_in_ready && o_out_valid), "in ready during output")
    `SM3_ASSERT(a_block_starts_rounds, wrap |=> (r_state == S_ROUND) && (r_round == 6'd0), "block did not start rounds")
    `SM3_ASSERT(a_rounds_end, (r_state == S_ROUND) && (r_round == LAST_ROUND) |=> (r_state == S_FINISH), "rounds did not end at 64")
    `SM3_ASSERT(a_last_out_idle, o_out_valid && i_out_ready && o_digest_last |=> (r_state == S_IDLE), "output did not end after eighth word")

endmodule

// File: rtl/core/sm3_dp.sv
module sm3_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sm3_pkg::t_cmd i_cmd,
    input  logic [31:0]   i_message_word,
    output logic [31:0]   o_digest_word
);
    import sm3_pkg::*;

    logic [31:0] r_cv [8];
    logic [31:0] r_w  [16];     // schedule window, r_w[0] is W[j]
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [31:0] r_t;           // round constant, already rotated for round j

    logic [31:0] w_new, a12, ss1, ss2, ffv, ggv, tt1, tt2;

    assign w_new = perm1(r_w[0] ^ r_w[7] ^ rotl(r_w[13], 15)) ^ rotl(r_w[3], 7) ^ r_w[10];

    always_comb begin
        a12 = rotl(r_a, 12);
        ss1 = rotl(a12 + r_e + r_t, 7);
        ss2 = ss1 ^ a12;
        if (i_cmd.round_hi) begin
            ffv = (r_a & r_b) | (r_a & r_c) | (r_b & r_c);
            ggv = (r_e & r_f) | (~r_e & r_g);
        end else begin
            ffv = r_a ^ r_b ^ r_c;
            ggv = r_e ^ r_f ^ r_g;
        end
        tt1 = ffv + r_d + ss2 + (r_w[0] ^ r_w[4]);
        tt2 = ggv + r_h + ss1 + r_w[0];
    end

    // schedule window: shift in message words, then expanded words
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_in || i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= i_cmd.round ? w_new : i_message_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a <= r_cv[0];
            r_b <= r_cv[1];
            r_c <= r_cv[2];
            r_d <= r_cv[3];
            r_e <= r_cv[4];
            r_f <= r_cv[5];
            r_g <= r_cv[6];
            r_h <= r_cv[7];
            r_t <= SM3_T_LOW;
        end else if (i_cmd.round) begin
            r_d <= r_c;
            r_c <= rotl(r_b, 9);
            r_b <= r_a;
            r_a <= tt1;
            r_h <= r_g;
            r_g <= rotl(r_f, 19);
            r_f <= r_e;
            r_e <= perm0(tt2);
            r_t <= i_cmd.t_switch ? SM3_T_HIGH_R16 : rotl(r_t, 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_iv) begin
            for (int i = 0; i < 8; i++) begin
                r_cv[i] <= SM3_IV[i];
            end
        end else if (i_cmd.finish) begin
            r_cv[0] <= r_cv[0] ^ r_a;
            r_cv[1] <= r_cv[1] ^ r_b;
            r_cv[2] <= r_cv[2] ^ r_c;
            r_cv[3] <= r_cv[3] ^ r_d;
            r_cv[4] <= r_cv[4] ^ r_e;
            r_cv[5] <= r_cv[5] ^ r_f;
            r_cv[6] <= r_cv[6] ^ r_g;
            r_cv[7] <= r_cv[7] ^ r_h;
        end
    end

    assign o_digest_word = r_cv[i_cmd.out_idx];

endmodule

// File: rtl/core/sm3_hash_core.sv
// SM3 hash core (256-bit digest) for messages that software has already padded.
// Feed the message as big-endian 32-bit words on the input channel; raise
// first_word on the first word of a message to restart from the standard
// initial value (without it, hashing continues from the current chaining
// value). Every 16 accepted words form a block; the core then stops taking
// words while it runs 64 compression rounds, one round per cycle in a single
// shared round unit, and then folds the result into the chaining value. When
// the word that completes a block carried final_word, the eight digest words
// follow on the output channel, most significant first, digest_last marking
// the eighth; a final flag on a word that does not complete a block is
// ignored. No new request is taken until all eight digest words have been
// delivered.
module sm3_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // message words
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_message_word,
    input  logic        i_first_word,
    input  logic        i_final_word,
    // digest words
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    import sm3_pkg::*;

    // command bundle: controller sequences the block, datapath holds
    // the schedule window, working variables and chaining value
    t_cmd cmd;

    sm3_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_first_word  (i_first_word),
        .i_final_word  (i_final_word),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_last (o_digest_last),
        .o_cmd         (cmd)
    );

    sm3_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_message_word (i_message_word),
        .o_digest_word  (o_digest_word)
    );

endmodule

// File: tb/tb_sm3_hash_core.sv
`timescale 1ns / 1ps

module tb_sm3_hash_core;

    localparam int RANDOM_ITEMS   = 240;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;

    // Keep these independent of the design package.
    localparam logic [31:0] T_EARLY = 32'h79cc4519;
    localparam logic [31:0] T_LATE  = 32'h7a879d8a;
    localparam logic [31:0] START_VALUE [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_digest_entry;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [31:0] message_word = '0;
    logic        first_word   = 1'b0;
    logic        final_word   = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [31:0] digest_word;
    logic        digest_last;

    // predictor state
    logic [31:0] chain_val [8];
    logic [31:0] blk_words [16];
    logic [3:0]  word_pos;

    t_digest_entry pending_digest_q [$];
    int            error_count = 0;
    int            idle_cycles = 0;
    int            rx_hold     = 0;
    bit            tx_burst    = 1'b0;
    bit            rx_burst    = 1'b0;

    sm3_hash_core uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_message_word (message_word),
        .i_first_word   (first_word),
        .i_final_word   (final_word),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_digest_word  (digest_word),
        .o_digest_last  (digest_last)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
        int unsigned k;
        k = n % 32;
        if (k == 0) return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] p0_mix(input logic [31:0] x);
        return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function automatic logic [31:0] p1_mix(input logic [31:0] x);
        return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

    // Expand the held block and fold 64 rounds into the chaining value.
    task automatic compress_block();
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tj;
        for (int j = 0; j < 16; j++) w[j] = blk_words[j];
        for (int j = 16; j < 68; j++)
            w[j] = p1_mix(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
        a = chain_val[0]; b = chain_val[1]; c = chain_val[2]; d = chain_val[3];
        e = chain_val[4]; f = chain_val[5]; g = chain_val[6]; h = chain_val[7];
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? T_EARLY : T_LATE;
            a12 = rol(a, 12);
            ss1 = rol(a12 + e + rol(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ffv = a ^ b ^ c;
                ggv = e ^ f ^ g;
            end else begin
                ffv = (a & b) | (a & c) | (b & c);
                ggv = (e & f) | (~e & g);
            end
            tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = ggv + h + ss1 + w[j];
            d = c;
            c = rol(b, 9);
            b = a;
            a = tt1;
            h = g;
            g = rol(f, 19);
            f = e;
            e = p0_mix(tt2);
        end
        chain_val[0] ^= a; chain_val[1] ^= b; chain_val[2] ^= c; chain_val[3] ^= d;
        chain_val[4] ^= e; chain_val[5] ^= f; chain_val[6] ^= g; chain_val[7] ^= h;
    endtask

    // Take one accepted word into the predictor; queue the digest on a final block.
    task automatic absorb_word(input logic [31:0] w, input logic first, input logic last);
        if (first) begin
            for (int i = 0; i < 8; i++) chain_val[i] = START_VALUE[i];
            word_pos = '0;
        end
        blk_words[word_pos] = w;
        word_pos = word_pos + 4'd1;
        if (word_pos == 4'd0) begin
            compress_block();
            if (last)
                for (int i = 0; i < 8; i++)
                    pending_digest_q.push_back('{word: chain_val[i], last: (i == 7)});
        end
    endtask

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'h0000_0000;
        if (pick == 1) return 32'hffff_ffff;
        return $urandom;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("MISMATCH %s: expected %h got %h", what, exp_v, got_v);
        error_count++;
    endtask

    // Present one request and hold it until the core takes it.
    task automatic send_word(input logic [31:0] w, input logic first, input logic last);
        int gap;
        gap = (tx_burst || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= w;
        first_word   <= first;
        final_word   <= last;
        do @(posedge clk); while (!in_ready);
        absorb_word(w, first, last);
    endtask

    // First and final together on word zero, a final mid-block, field extremes.
    task automatic test_flags_and_extremes();
        logic [31:0] w;
        for (int i = 0; i < 16; i++) begin
            case (i)
                0, 10:   w = 32'h0000_0000;
                1, 7:    w = 32'hffff_ffff;
                2:       w = 32'h8000_0000;
                3:       w = 32'h0000_0001;
                15:      w = 32'hffff_ffff;
                default: w = $urandom;
            endcase
            send_word(w, i == 0, i == 0 || i == 7 || i == 15);
        end
    endtask

    // Standard one-block message, sent without first_word: chain from the last digest.
    task automatic test_chained_without_first();
        logic [31:0] w;
        for (int i = 0; i < 16; i++) begin
            w = (i == 0) ? 32'h6162_6380 : (i == 15) ? 32'h0000_0018 : 32'h0;
            send_word(w, 1'b0, i == 15);
        end
    endtask

    // Mostly well-formed messages of one to three blocks; some cut short,
    // some without first_word, stray final flags sprinkled in.
    task automatic test_random_messages();
        int sent;
        int blocks;
        int len;
        int pick;
        bit broken;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            pick     = $urandom_range(0, 9);
            blocks   = (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
            broken   = ($urandom_range(0, 9) == 0);
            len      = broken ? $urandom_range(1, 15) : 16 * blocks;
            for (int i = 0; i < len; i++)
                send_word(rand_word(), i == 0 && $urandom_range(0, 9) != 0,
                          (!broken && i == len - 1) || $urandom_range(0, 9) == 0);
            sent += len;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // Receiver: random back-pressure, off during burst stretches.
    always @(posedge clk) begin
        if (!rx_burst && rx_hold != 0) begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end else begin
            out_ready <= 1'b1;
            rx_hold   <= (rx_burst || $urandom_range(0, 3) != 0) ? 0 : idle_len();
        end
    end

    // Compare each delivered digest word with the oldest pending one.
    always @(posedge clk) begin
        t_digest_entry exp_e;
        if (rst_n && out_valid && out_ready) begin
            if (pending_digest_q.size() == 0) begin
                report_mismatch("digest word with none pending", 32'h0, digest_word);
            end else begin
                exp_e = pending_digest_q.pop_front();
                if (digest_word !== exp_e.word)
                    report_mismatch("digest_word", exp_e.word, digest_word);
                if (digest_last !== exp_e.last)
                    report_mismatch("digest_last", {31'b0, exp_e.last}, {31'b0, digest_last});
            end
        end
    end

    // Drop the run if neither channel moves for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sm3_hash_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) chain_val[i] = START_VALUE[i];
        for (int i = 0; i < 16; i++) blk_words[i] = '0;
        word_pos = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_flags_and_extremes();
        test_chained_without_first();
        test_random_messages();

        in_valid <= 1'b0;
        while (pending_digest_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("sm3_hash_core verification clean");
        end else begin
            $display("sm3_hash_core verification failed");
        end
        $finish;
    end

endmodule
